// File: hdl/qpf_pkg.sv
// Shared constants, register codes and controller command type for the quadrant position filter.
package qpf_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int COORD_FRAC_BITS = 16;

    localparam int COORD_W  = COORD_FRAC_BITS + 5;
    localparam int THR_W    = 8;
    localparam int HL_W     = 20;
    localparam int ALPHA_W  = 16;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 2;

    // sums and differences of four samples need two extra bits
    localparam int DIFF_W   = SAMPLE_BITS + 2;
    localparam int NUM_W    = DIFF_W - 1 + HL_W;
    localparam int DSH_W    = DIFF_W + COORD_W - 1;
    localparam int BIG_W    = DIFF_W + COORD_W;
    localparam int CNT_W    = $clog2(COORD_W);
    localparam int PA_W     = ALPHA_W + 1 + COORD_W;
    localparam int PB_W     = ALPHA_W + 2 + COORD_W;
    localparam int ACC_W    = PB_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA           = 2'd2;

    localparam logic [THR_W-1:0]   RST_LIGHT_THRESHOLD = '0;
    localparam logic [HL_W-1:0]    RST_HALF_LENGTH     = HL_W'(147456);
    localparam logic [ALPHA_W-1:0] RST_ALPHA           = ALPHA_W'(58982);

    typedef struct packed {
        logic load;
        logic setup;
        logic mul;
        logic check;
        logic div_step;
        logic raw;
        logic fmul;
        logic commit;
    } t_cmd;

endpackage

// File: hdl/qpf_ctrl.sv
// Sequencing state machine and output valid flag for the quadrant position filter.
module qpf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output qpf_pkg::t_cmd o_cmd
);
    import qpf_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SETUP  = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_RAW    = 3'd5;
    localparam logic [2:0] S_FMUL   = 3'd6;
    localparam logic [2:0] S_COMMIT = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             slot_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign slot_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_cnt       = CNT_W'(COORD_W - 1);
                n_state     = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_RAW;
                end
            end
            S_RAW: begin
                o_cmd.raw = 1'b1;
                n_state   = S_FMUL;
            end
            S_FMUL: begin
                o_cmd.fmul = 1'b1;
                n_state    = S_COMMIT;
            end
            S_COMMIT: begin
                // hold until the output register can take the transaction
                if (slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: hdl/qpf_datapath.sv
// Datapath: configuration registers, channel sums, two restoring dividers and the smoothing filters.
module qpf_datapath (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  qpf_pkg::t_cmd                             i_cmd,
    input  logic                                      i_cfg_we,
    input  logic [qpf_pkg::CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [qpf_pkg::CFG_W-1:0]                 i_cfg_data,
    input  logic signed [qpf_pkg::SAMPLE_BITS-1:0]    i_sample_a,
    input  logic signed [qpf_pkg::SAMPLE_BITS-1:0]    i_sample_b,
    input  logic signed [qpf_pkg::SAMPLE_BITS-1:0]    i_sample_c,
    input  logic signed [qpf_pkg::SAMPLE_BITS-1:0]    i_sample_d,
    output logic signed [qpf_pkg::COORD_W-1:0]        o_x_pos,
    output logic signed [qpf_pkg::COORD_W-1:0]        o_y_pos,
    output logic                                      o_light_valid,
    output logic                                      o_zero_sum_fault
);
    import qpf_pkg::*;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-1:0]        NEG_LIMIT = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [ALPHA_W:0]          ALPHA_ONE = {1'b1, {ALPHA_W{1'b0}}};

    function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
        mag = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    endfunction

    function automatic logic signed [DIFF_W-1:0] sext(input logic signed [SAMPLE_BITS-1:0] v);
        sext = {{(DIFF_W-SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
    endfunction

    // signed raw coordinate from quotient magnitude, with saturation
    function automatic logic signed [COORD_W-1:0] sat_raw(input logic [COORD_W-1:0] q,
                                                          input logic neg, input logic ovf,
                                                          input logic zero);
        logic signed [COORD_W-1:0] res;
        if (zero) begin
            res = '0;
        end else if (!neg) begin
            res = (ovf || q > COORD_W'(COORD_MAX)) ? COORD_MAX : $signed(q);
        end else begin
            res = (ovf || q > NEG_LIMIT) ? COORD_MIN : $signed(COORD_W'(-q));
        end
        sat_raw = res;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_filt(
            input logic signed [ACC_W-ALPHA_W-1:0] v);
        logic signed [COORD_W-1:0] res;
        if (v > (ACC_W-ALPHA_W)'(COORD_MAX)) begin
            res = COORD_MAX;
        end else if (v < (ACC_W-ALPHA_W)'(COORD_MIN)) begin
            res = COORD_MIN;
        end else begin
            res = v[COORD_W-1:0];
        end
        clamp_filt = res;
    endfunction

    // configuration and filter state
    logic [THR_W-1:0]          r_thr;
    logic [HL_W-1:0]           r_half_len;
    logic [ALPHA_W-1:0]        r_alpha;
    logic signed [COORD_W-1:0] r_filt_x, r_filt_y;

    // working registers
    logic signed [SAMPLE_BITS-1:0] r_a, r_b, r_c, r_d;
    logic [DIFF_W-1:0]         r_sum_mag;
    logic [DIFF_W-2:0]         r_dx_mag, r_dy_mag;
    logic                      r_neg_x, r_neg_y, r_lit, r_zero;
    logic [NUM_W-1:0]          r_rem_x, r_rem_y;
    logic [DSH_W-1:0]          r_dsh;
    logic                      r_ovf_x, r_ovf_y;
    logic [COORD_W-1:0]        r_q_x, r_q_y;
    logic signed [COORD_W-1:0] r_raw_x, r_raw_y;
    logic signed [PA_W-1:0]    r_pa_x, r_pa_y;
    logic signed [PB_W-1:0]    r_pb_x, r_pb_y;

    logic signed [DIFF_W-1:0]  ea, eb, ec, ed, sum, dx, dy;
    logic [DIFF_W-1:0]         dx_abs, dy_abs;
    logic [SAMPLE_BITS:0]      ma, mb, mc, md, thr_ext;
    logic                      dark;
    logic [BIG_W-1:0]          div_limit;
    logic [DSH_W-1:0]          trial_x, trial_y;
    logic                      ge_x, ge_y;
    logic [ALPHA_W:0]          beta;
    logic signed [ACC_W-1:0]   acc_x, acc_y;
    logic signed [COORD_W-1:0] n_filt_x, n_filt_y;

    always_comb begin
        ea      = sext(r_a);
        eb      = sext(r_b);
        ec      = sext(r_c);
        ed      = sext(r_d);
        sum     = ea + eb + ec + ed;
        dx      = (eb + ec) - (ea + ed);
        dy      = (eb + ed) - (ea + ec);
        dx_abs  = mag(dx);
        dy_abs  = mag(dy);
        ma      = (SAMPLE_BITS+1)'(mag(ea));
        mb      = (SAMPLE_BITS+1)'(mag(eb));
        mc      = (SAMPLE_BITS+1)'(mag(ec));
        md      = (SAMPLE_BITS+1)'(mag(ed));
        thr_ext = (SAMPLE_BITS+1)'(r_thr);
        dark    = (ma < thr_ext) && (mb < thr_ext) && (mc < thr_ext) && (md < thr_ext);
    end

    assign div_limit = BIG_W'(r_sum_mag) << COORD_W;
    assign ge_x      = DSH_W'(r_rem_x) >= r_dsh;
    assign ge_y      = DSH_W'(r_rem_y) >= r_dsh;
    assign trial_x   = DSH_W'(r_rem_x) - r_dsh;
    assign trial_y   = DSH_W'(r_rem_y) - r_dsh;

    assign beta     = ALPHA_ONE - (ALPHA_W+1)'(r_alpha);
    assign acc_x    = ACC_W'(r_pa_x) + ACC_W'(r_pb_x);
    assign acc_y    = ACC_W'(r_pa_y) + ACC_W'(r_pb_y);
    assign n_filt_x = clamp_filt(acc_x[ACC_W-1:ALPHA_W]);
    assign n_filt_y = clamp_filt(acc_y[ACC_W-1:ALPHA_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= RST_LIGHT_THRESHOLD;
            r_half_len <= RST_HALF_LENGTH;
            r_alpha    <= RST_ALPHA;
            r_filt_x   <= '0;
            r_filt_y   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_LIGHT_THRESHOLD: r_thr      <= i_cfg_data[THR_W-1:0];
                    REG_HALF_LENGTH:     r_half_len <= i_cfg_data[HL_W-1:0];
                    REG_ALPHA:           r_alpha    <= i_cfg_data[ALPHA_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.commit) begin
                // no light clears both filters
                r_filt_x <= r_lit ? n_filt_x : '0;
                r_filt_y <= r_lit ? n_filt_y : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= i_sample_a;
            r_b <= i_sample_b;
            r_c <= i_sample_c;
            r_d <= i_sample_d;
        end
        if (i_cmd.setup) begin
            r_sum_mag <= mag(sum);
            r_dx_mag  <= dx_abs[DIFF_W-2:0];
            r_dy_mag  <= dy_abs[DIFF_W-2:0];
            r_neg_x   <= dx[DIFF_W-1] ^ sum[DIFF_W-1];
            r_neg_y   <= dy[DIFF_W-1] ^ sum[DIFF_W-1];
            r_lit     <= !dark;
            r_zero    <= (sum == '0);
        end
        if (i_cmd.mul) begin
            r_rem_x <= NUM_W'(r_dx_mag) * NUM_W'(r_half_len);
            r_rem_y <= NUM_W'(r_dy_mag) * NUM_W'(r_half_len);
        end
        if (i_cmd.check) begin
            // a quotient that cannot fit in the coordinate width saturates outright
            r_ovf_x <= BIG_W'(r_rem_x) >= div_limit;
            r_ovf_y <= BIG_W'(r_rem_y) >= div_limit;
            r_dsh   <= DSH_W'(r_sum_mag) << (COORD_W - 1);
            r_q_x   <= '0;
            r_q_y   <= '0;
        end
        if (i_cmd.div_step) begin
            if (ge_x) begin
                r_rem_x <= trial_x[NUM_W-1:0];
            end
            if (ge_y) begin
                r_rem_y <= trial_y[NUM_W-1:0];
            end
            r_q_x <= {r_q_x[COORD_W-2:0], ge_x};
            r_q_y <= {r_q_y[COORD_W-2:0], ge_y};
            r_dsh <= r_dsh >> 1;
        end
        if (i_cmd.raw) begin
            r_raw_x <= sat_raw(r_q_x, r_neg_x, r_ovf_x, r_zero);
            r_raw_y <= sat_raw(r_q_y, r_neg_y, r_ovf_y, r_zero);
        end
        if (i_cmd.fmul) begin
            r_pa_x <= PA_W'($signed({1'b0, r_alpha})) * PA_W'(r_filt_x);
            r_pa_y <= PA_W'($signed({1'b0, r_alpha})) * PA_W'(r_filt_y);
            r_pb_x <= PB_W'($signed({1'b0, beta})) * PB_W'(r_raw_x);
            r_pb_y <= PB_W'($signed({1'b0, beta})) * PB_W'(r_raw_y);
        end
        if (i_cmd.commit) begin
            o_x_pos          <= r_lit ? n_filt_x : '0;
            o_y_pos          <= r_lit ? n_filt_y : '0;
            o_light_valid    <= r_lit;
            o_zero_sum_fault <= r_lit && r_zero;
        end
    end

endmodule

// File: hdl/quadrant_psd_position_filter_core.sv
// Top level: quadrant photodiode position with exponential smoothing.
// Takes four signed channel samples per transaction and returns one filtered (x, y) position
// in signed Q.16 millimetres, with a light flag and a zero-sum fault flag. One item is in
// work at a time: the input stalls from acceptance until the item commits, chiefly for the two
// restoring dividers (x and y side by side) that produce one quotient bit per cycle, plus setup,
// multiply, overflow check, saturate and filter steps. The result sits in an output register, so
// the next item is taken while an earlier result still waits; a stall of the output lasting past
// the next item's filter step holds it until the register frees. The user must write configuration
// registers through the plain write port only while idle; the block does not enforce this.
module quadrant_psd_position_filter_core (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [qpf_pkg::CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [qpf_pkg::CFG_W-1:0]                 i_cfg_data,
    input  logic                                      i_in_valid,
    output logic                                      o_in_stall,
    input  logic signed [qpf_pkg::SAMPLE_BITS-1:0]    i_sample_a,
    input  logic signed [qpf_pkg::SAMPLE_BITS-1:0]    i_sample_b,
    input  logic signed [qpf_pkg::SAMPLE_BITS-1:0]    i_sample_c,
    input  logic signed [qpf_pkg::SAMPLE_BITS-1:0]    i_sample_d,
    output logic                                      o_out_valid,
    input  logic                                      i_out_stall,
    output logic signed [qpf_pkg::COORD_W-1:0]        o_x_pos,
    output logic signed [qpf_pkg::COORD_W-1:0]        o_y_pos,
    output logic                                      o_light_valid,
    output logic                                      o_zero_sum_fault
);
    import qpf_pkg::*;

    t_cmd cmd;

    qpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    qpf_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_sample_a       (i_sample_a),
        .i_sample_b       (i_sample_b),
        .i_sample_c       (i_sample_c),
        .i_sample_d       (i_sample_d),
        .o_x_pos          (o_x_pos),
        .o_y_pos          (o_y_pos),
        .o_light_valid    (o_light_valid),
        .o_zero_sum_fault (o_zero_sum_fault)
    );

endmodule
